>>> hdl/assert_macros.svh
// assertion macros shared by the rice block decoder modules
// expects clk and arst_n in the scope of the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication or plain property, checked on every rising edge out of reset
`define RBD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition that must never hold
`define RBD_ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

>>> hdl/rbd_pkg.sv
// rbd_pkg: constants and controller/datapath interface types for the rice block decoder
// no dependencies
package rbd_pkg;

	localparam int WORD_BITS = 32;
	localparam int POS_W = $clog2(WORD_BITS);
	localparam int K_W = 5;
	localparam int FBT_W = K_W + 1;
	localparam int COUNT_W = 16;
	localparam logic [COUNT_W-1:0] VALUE_COUNT_RESET = 16'd128;

	// commands from the controller
	typedef struct packed {
		logic accept;
		logic step;
		logic flush;
	} cmd_t;

	// status from the datapath
	typedef struct packed {
		logic phase;
		logic complete;
		logic blk_end;
		logic last_bit;
		logic pend_valid;
		logic out_free;
	} status_t;

endpackage

>>> hdl/rbd_ctrl.sv
// rbd_ctrl: state machine sequencing word accept, the bit walk and the final flush
// depends on rbd_pkg and assert_macros.svh
`include "assert_macros.svh"

module rbd_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            stream_valid,
	output logic            stream_stall,
	input  rbd_pkg::status_t status,
	output rbd_pkg::cmd_t    cmd
);
	import rbd_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_WALK  = 2'd1;
	localparam logic [1:0] ST_FLUSH = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       step_ok;

	// a finished value cannot move on while the older one still waits for the output
	assign step_ok = !(status.complete && status.pend_valid && !status.out_free);

	assign stream_stall = (state_q != ST_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				cmd.accept = stream_valid;
				if (stream_valid && status.phase) begin
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				cmd.step = step_ok;
				if (step_ok && ((status.complete && status.blk_end) || status.last_bit)) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				cmd.flush = 1'b1;
				if (!status.pend_valid || status.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`RBD_ASSERT(a_step_has_room, cmd.step |-> (!status.complete || !status.pend_valid || status.out_free), "walk stepped with no room for a finished word")
	`RBD_ASSERT(a_flush_leaves, (state_q == ST_FLUSH && !status.pend_valid) |=> (state_q == ST_IDLE), "flush did not return to idle")
	`RBD_ASSERT(a_last_bit_flush, (cmd.step && status.last_bit) |=> (state_q == ST_FLUSH), "walk ran past the end of the word")

endmodule

>>> hdl/rbd_datapath.sv
// rbd_datapath: bit walker, value accumulator, pending value and output register
// depends on rbd_pkg and assert_macros.svh
`include "assert_macros.svh"

module rbd_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  rbd_pkg::cmd_t               cmd,
	output rbd_pkg::status_t            status,
	input  logic [rbd_pkg::WORD_BITS-1:0] stream_word,
	input  logic                        cfg_valid,
	input  logic [rbd_pkg::COUNT_W-1:0] cfg_data,
	output logic                        value_valid,
	input  logic                        value_stall,
	output logic [rbd_pkg::WORD_BITS-1:0] value,
	output logic                        block_end,
	output logic                        last
);
	import rbd_pkg::*;

	logic                 phase_q;
	logic [K_W-1:0]       k_q;
	logic [FBT_W-1:0]     fbt_q;
	logic                 unary_q;
	logic [WORD_BITS-1:0] accum_q;
	logic [COUNT_W-1:0]   done_q;
	logic [COUNT_W-1:0]   count_q;
	logic [WORD_BITS-1:0] word_q;
	logic [POS_W-1:0]     pos_q;
	logic                 pend_valid_q;
	logic [WORD_BITS-1:0] pend_value_q;
	logic                 pend_end_q;
	logic                 value_valid_q;
	logic [WORD_BITS-1:0] value_q;
	logic                 block_end_q;
	logic                 last_q;

	logic                 raw;
	logic                 bit_in;
	logic                 complete;
	logic [COUNT_W-1:0]   done_next;
	logic                 blk_end;
	logic                 out_free;
	logic                 push_mid;
	logic                 push_flush;

	assign bit_in    = word_q[0];
	assign raw       = !unary_q && (fbt_q < {1'b0, k_q});
	assign complete  = !raw && !bit_in;
	assign done_next = done_q + COUNT_W'(1);
	assign blk_end   = (done_next == count_q);
	assign out_free  = !value_valid_q || !value_stall;
	assign push_mid  = cmd.step && complete && pend_valid_q;
	assign push_flush = cmd.flush && pend_valid_q && out_free;

	assign status.phase      = phase_q;
	assign status.complete   = complete;
	assign status.blk_end    = blk_end;
	assign status.last_bit   = (pos_q == POS_W'(WORD_BITS - 1));
	assign status.pend_valid = pend_valid_q;
	assign status.out_free   = out_free;

	assign value_valid = value_valid_q;
	assign value       = value_q;
	assign block_end   = block_end_q;
	assign last        = last_q;

	// block length register; writes must arrive only while idle, the block itself does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= VALUE_COUNT_RESET;
		end else if (cfg_valid) begin
			count_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= 1'b0;
			k_q          <= '0;
			fbt_q        <= '0;
			unary_q      <= 1'b0;
			accum_q      <= '0;
			done_q       <= '0;
			pos_q        <= '0;
			pend_valid_q <= 1'b0;
		end else begin
			if (cmd.accept) begin
				if (!phase_q) begin
					// header word: only the low bits carry k
					k_q     <= stream_word[K_W-1:0];
					phase_q <= 1'b1;
					done_q  <= '0;
					fbt_q   <= '0;
					unary_q <= 1'b0;
					accum_q <= '0;
				end else begin
					pos_q <= '0;
				end
			end
			if (cmd.step) begin
				pos_q <= pos_q + POS_W'(1);
				if (raw) begin
					accum_q[fbt_q[K_W-1:0]] <= bit_in;
					fbt_q <= fbt_q + FBT_W'(1);
				end else if (bit_in) begin
					unary_q <= 1'b1;
					accum_q <= accum_q + (WORD_BITS'(1) << k_q);
				end else begin
					pend_valid_q <= 1'b1;
					fbt_q        <= '0;
					unary_q      <= 1'b0;
					accum_q      <= '0;
					if (blk_end) begin
						phase_q <= 1'b0;
						done_q  <= '0;
					end else begin
						done_q <= done_next;
					end
				end
			end
			if (push_flush) begin
				pend_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.accept && phase_q) begin
			word_q <= stream_word;
		end else if (cmd.step) begin
			word_q <= word_q >> 1;
		end
		if (cmd.step && complete) begin
			pend_value_q <= accum_q;
			pend_end_q   <= blk_end;
		end
		if (push_mid || push_flush) begin
			value_q     <= pend_value_q;
			block_end_q <= pend_end_q;
			last_q      <= push_flush;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_valid_q <= 1'b0;
		end else if (push_mid || push_flush) begin
			value_valid_q <= 1'b1;
		end else if (out_free) begin
			value_valid_q <= 1'b0;
		end
	end

	`RBD_ASSERT(a_push_room, (push_mid || push_flush) |-> out_free, "output word overwritten while stalled")
	`RBD_ASSERT(a_block_end_header, (cmd.step && complete && blk_end) |=> !phase_q, "block end did not return to header phase")
	`RBD_ASSERT(a_header_phase, (cmd.accept && !phase_q) |=> (phase_q && done_q == '0), "header word did not start a block")

endmodule

>>> hdl/rice_block_decoder.sv
// rice_block_decoder: top level of the rice block decoder
// depends on rbd_pkg, rbd_ctrl and rbd_datapath
//
//  channel   direction  handshake                 payload
//  stream    in         stream_valid/stream_stall stream_word[31:0]
//  value     out        value_valid/value_stall   value[31:0], block_end, last
//  cfg       in         cfg_valid/cfg_ready       cfg_data[15:0] (value_count)
//
// a header word is taken while the controller stays idle; a data word is accepted,
// then walked bit by bit through the walker shift register (32 bits, fewer when the block
// ends inside the word) and the held value is then flushed
// arst_n clears the walker and sets value_count to 128
// value_stall holds the walk when a second finished value finds the output full,
// and holds the flush until the held value has moved out
// cfg_ready is always high
module rice_block_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        stream_valid,
	output logic        stream_stall,
	input  logic [31:0] stream_word,
	output logic        value_valid,
	input  logic        value_stall,
	output logic [31:0] value,
	output logic        block_end,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);
	import rbd_pkg::*;

	cmd_t    cmd;
	status_t status;

	assign cfg_ready = 1'b1;

	rbd_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.stream_valid (stream_valid),
		.stream_stall (stream_stall),
		.status       (status),
		.cmd          (cmd)
	);

	rbd_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.stream_word (stream_word),
		.cfg_valid   (cfg_valid),
		.cfg_data    (cfg_data),
		.value_valid (value_valid),
		.value_stall (value_stall),
		.value       (value),
		.block_end   (block_end),
		.last        (last)
	);

endmodule

>>> test/rice_block_decoder_tb.sv
`timescale 1ns / 100ps
// rice_block_decoder_tb: self-checking bench for the rice block decoder
// depends on rbd_pkg and rice_block_decoder; every decoded value is predicted and compared in order
module rice_block_decoder_tb;

	localparam int SETTLE_CYCLES = 48;
	localparam int QUIET_LIMIT = 3000;
	localparam int RANDOM_WORDS = 74;

	typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		logic [31:0] data;
		int          reps;
		logic        typed;
		int          n_out;
		logic [31:0] out_value;
		logic        out_end;
	} stim_row_t;

	typedef struct packed {
		logic [31:0] word;
		logic        typed;
		int          n_out;
		logic [31:0] out_value;
		logic        out_end;
	} stream_item_t;

	typedef struct packed {
		logic [31:0] value;
		logic        block_end;
		logic        last;
	} decoded_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        stream_valid = 1'b0;
	logic        stream_stall;
	logic [31:0] stream_word = '0;
	logic        value_valid;
	logic        value_stall = 1'b0;
	logic [31:0] value;
	logic        block_end;
	logic        last;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data = '0;

	// decoder state as predicted
	logic        dec_in_block;
	logic [4:0]  dec_k;
	logic [5:0]  dec_raw_taken;
	logic        dec_in_run;
	logic [31:0] dec_acc;
	logic [15:0] dec_done;
	logic [15:0] dec_count;

	decoded_t     word_out [rbd_pkg::WORD_BITS];
	decoded_t     pending_values [$];
	stream_item_t word_queue [$];
	stream_item_t cur_item;
	stim_row_t    directed_rows [$];

	int          send_idle_pct = 0;
	int          stall_pct = 0;
	int          words_left = 0;
	logic        cfg_req = 1'b0;
	logic [15:0] cfg_req_data = '0;
	int          errors = 0;
	int          words_in = 0;
	int          values_checked = 0;
	int          block_ends = 0;
	int          quiet_cycles = 0;

	rice_block_decoder dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic clear_value();
		dec_raw_taken = '0;
		dec_in_run = 1'b0;
		dec_acc = '0;
	endtask

	// takes k from a header word, or walks a data word bit by bit, leaving its values in word_out
	task automatic decode_word(input logic [31:0] w, output int n);
		int pos;
		logic stop;
		n = 0;
		stop = 1'b0;
		if (!dec_in_block) begin
			dec_k = w[4:0];
			dec_in_block = 1'b1;
			dec_done = '0;
			clear_value();
		end else begin
			for (pos = 0; pos < rbd_pkg::WORD_BITS && !stop; pos++) begin
				if (!dec_in_run && dec_raw_taken < {1'b0, dec_k}) begin
					dec_acc[dec_raw_taken[4:0]] = w[pos];
					dec_raw_taken = dec_raw_taken + 6'd1;
				end else begin
					dec_in_run = 1'b1;
					if (w[pos]) begin
						dec_acc = dec_acc + (32'd1 << dec_k);
					end else begin
						dec_done = dec_done + 16'd1;
						word_out[n].value = dec_acc;
						word_out[n].block_end = (dec_done == dec_count);
						word_out[n].last = 1'b0;
						n++;
						clear_value();
						// rest of the word is padding
						if (dec_done == dec_count) begin
							dec_in_block = 1'b0;
							dec_done = '0;
							stop = 1'b1;
						end
					end
				end
			end
			if (n > 0)
				word_out[n-1].last = 1'b1;
		end
	endtask

	function automatic logic [31:0] next_random_word();
		int pick;
		pick = $urandom_range(99);
		if (!dec_in_block)
			return $urandom;
		if (pick < 50)
			return $urandom;
		if (pick < 62)
			return '1;
		if (pick < 72)
			return '0;
		if (pick < 86)
			return $urandom & $urandom & $urandom;
		return $urandom | $urandom;
	endfunction

	always @(posedge clk or negedge arst_n) begin : bench_loop
		int n;
		logic active;
		decoded_t want;
		decoded_t typed_val;
		if (!arst_n) begin
			stream_valid <= 1'b0;
			stream_word <= '0;
			value_stall <= 1'b0;
			cfg_valid <= 1'b0;
			cfg_data <= '0;
			dec_count = rbd_pkg::VALUE_COUNT_RESET;
			dec_in_block = 1'b0;
			dec_k = '0;
			dec_done = '0;
			clear_value();
			quiet_cycles = 0;
		end else begin
			active = 1'b0;

			if (value_valid && !value_stall) begin
				active = 1'b1;
				if (pending_values.size() == 0) begin
					$error("value: no result expected, got %h", value);
					errors++;
				end else begin
					want = pending_values.pop_front();
					if (value !== want.value) begin
						$error("value: expected %h, got %h", want.value, value);
						errors++;
					end
					if (block_end !== want.block_end) begin
						$error("block_end: expected %b, got %b", want.block_end, block_end);
						errors++;
					end
					if (last !== want.last) begin
						$error("last: expected %b, got %b", want.last, last);
						errors++;
					end
					values_checked++;
					if (want.block_end)
						block_ends++;
				end
			end
			value_stall <= ($urandom_range(99) < stall_pct);

			if (cfg_valid && cfg_ready) begin
				active = 1'b1;
				dec_count = cfg_data;
				cfg_valid <= 1'b0;
			end else if (!cfg_valid && cfg_req) begin
				cfg_data <= cfg_req_data;
				cfg_valid <= 1'b1;
				cfg_req = 1'b0;
			end

			if (stream_valid && !stream_stall) begin
				active = 1'b1;
				words_in++;
				decode_word(stream_word, n);
				if (cur_item.typed) begin
					for (int i = 0; i < cur_item.n_out; i++) begin
						typed_val.value = cur_item.out_value;
						typed_val.block_end = (i == cur_item.n_out - 1) ? cur_item.out_end : 1'b0;
						typed_val.last = (i == cur_item.n_out - 1);
						pending_values.push_back(typed_val);
					end
				end else begin
					for (int i = 0; i < n; i++)
						pending_values.push_back(word_out[i]);
				end
			end

			// a stalled word holds; otherwise present the next one or idle
			if (!(stream_valid && stream_stall)) begin
				if ($urandom_range(99) < send_idle_pct) begin
					stream_valid <= 1'b0;
					stream_word <= $urandom;
				end else if (word_queue.size() > 0) begin
					cur_item = word_queue.pop_front();
					stream_valid <= 1'b1;
					stream_word <= cur_item.word;
				end else if (words_left > 0) begin
					cur_item.word = next_random_word();
					cur_item.typed = 1'b0;
					cur_item.n_out = 0;
					cur_item.out_value = '0;
					cur_item.out_end = 1'b0;
					words_left--;
					stream_valid <= 1'b1;
					stream_word <= cur_item.word;
				end else begin
					stream_valid <= 1'b0;
				end
			end

			if (active)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	task automatic add_row(input row_kind_t kind, input logic [31:0] data, input int reps,
			input logic typed, input int n_out, input logic [31:0] out_value,
			input logic out_end);
		stim_row_t row;
		row.kind = kind;
		row.data = data;
		row.reps = reps;
		row.typed = typed;
		row.n_out = n_out;
		row.out_value = out_value;
		row.out_end = out_end;
		directed_rows.push_back(row);
	endtask

	// everything sent has come back and the walker has had time to drain
	task automatic settle();
		@(negedge clk);
		while (word_queue.size() > 0 || words_left > 0 || stream_valid ||
				pending_values.size() > 0 || cfg_valid || cfg_req)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_count(input logic [15:0] v);
		cfg_req_data = v;
		cfg_req = 1'b1;
		@(negedge clk);
		while (cfg_req || cfg_valid)
			@(negedge clk);
	endtask

	initial begin : run
		stim_row_t row;
		stream_item_t item;
		logic [15:0] cnt;

		// reset count of 128, k = 0, junk above the k field
		add_row(ROW_WORD, 32'hffff_ffe0, 1, 1'b1, 0, 32'h0, 1'b0);
		add_row(ROW_WORD, 32'h0000_0000, 1, 1'b1, 32, 32'h0, 1'b0);
		// unary run across the whole word, no value finished
		add_row(ROW_WORD, 32'hffff_ffff, 1, 1'b1, 0, 32'h0, 1'b0);
		add_row(ROW_WORD, 32'hffff_fffe, 1, 1'b0, 0, 32'h0, 1'b0);
		add_row(ROW_WORD, 32'h0000_0000, 2, 1'b0, 0, 32'h0, 1'b0);
		add_row(ROW_WORD, 32'h0000_0000, 1, 1'b1, 31, 32'h0, 1'b1);
		// k = 31 with wrapping unary adds
		add_row(ROW_CFG, 32'd2, 1, 1'b0, 0, 32'h0, 1'b0);
		add_row(ROW_WORD, 32'habcd_ef1f, 1, 1'b1, 0, 32'h0, 1'b0);
		add_row(ROW_WORD, 32'hffff_ffff, 1, 1'b1, 0, 32'h0, 1'b0);
		add_row(ROW_WORD, 32'hffff_fffe, 1, 1'b1, 1, 32'hffff_ffff, 1'b0);
		add_row(ROW_WORD, 32'h0000_0003, 1, 1'b1, 1, 32'h7fff_ffff, 1'b1);
		add_row(ROW_CFG, 32'd1, 1, 1'b0, 0, 32'h0, 1'b0);
		add_row(ROW_WORD, 32'h0000_0004, 1, 1'b1, 0, 32'h0, 1'b0);
		add_row(ROW_WORD, 32'h0000_0035, 1, 1'b1, 1, 32'd37, 1'b1);
		// zero count: the block runs past 64 values, then a count of 70 closes it
		add_row(ROW_CFG, 32'd0, 1, 1'b0, 0, 32'h0, 1'b0);
		add_row(ROW_WORD, 32'h0000_0000, 1, 1'b1, 0, 32'h0, 1'b0);
		add_row(ROW_WORD, 32'h0000_0000, 2, 1'b1, 32, 32'h0, 1'b0);
		add_row(ROW_CFG, 32'd70, 1, 1'b0, 0, 32'h0, 1'b0);
		add_row(ROW_WORD, 32'h0000_0000, 1, 1'b1, 6, 32'h0, 1'b1);
		// count lowered mid-block, still above the values done
		add_row(ROW_WORD, 32'h0000_0001, 1, 1'b1, 0, 32'h0, 1'b0);
		add_row(ROW_WORD, 32'h0000_0000, 1, 1'b1, 16, 32'h0, 1'b0);
		add_row(ROW_CFG, 32'd20, 1, 1'b0, 0, 32'h0, 1'b0);
		add_row(ROW_WORD, 32'h5555_5555, 1, 1'b1, 4, 32'h1, 1'b1);
		add_row(ROW_CFG, 32'd65535, 1, 1'b0, 0, 32'h0, 1'b0);
		add_row(ROW_WORD, 32'hffff_fff0, 1, 1'b0, 0, 32'h0, 1'b0);
		add_row(ROW_WORD, 32'h1234_5678, 1, 1'b0, 0, 32'h0, 1'b0);
		add_row(ROW_WORD, 32'h8000_0001, 1, 1'b0, 0, 32'h0, 1'b0);
		add_row(ROW_WORD, 32'hffff_ffff, 1, 1'b0, 0, 32'h0, 1'b0);
		add_row(ROW_WORD, 32'h0000_0000, 1, 1'b0, 0, 32'h0, 1'b0);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		for (int r = 0; r < directed_rows.size(); r++) begin
			row = directed_rows[r];
			if (row.kind == ROW_CFG) begin
				settle();
				write_count(row.data[15:0]);
			end else begin
				@(negedge clk);
				item.word = row.data;
				item.typed = row.typed;
				item.n_out = row.n_out;
				item.out_value = row.out_value;
				item.out_end = row.out_end;
				for (int i = 0; i < row.reps; i++)
					word_queue.push_back(item);
			end
		end

		// random blocks under each idling pattern
		for (int ph = 0; ph < 4; ph++) begin
			settle();
			send_idle_pct = (ph == 1) ? 83 : (ph == 3) ? 27 : 0;
			stall_pct = (ph == 2) ? 83 : (ph == 3) ? 27 : 0;
			cnt = 16'($urandom_range(20, 1));
			// keep the open block reachable rather than wrapping
			if (dec_in_block && cnt <= dec_done)
				cnt = dec_done + 16'($urandom_range(4, 1));
			write_count(cnt);
			@(negedge clk);
			words_left = RANDOM_WORDS;
		end
		settle();

		$display("summary: %0d stream words in, %0d values checked, %0d block ends",
			words_in, values_checked, block_ends);
		$display("summary: k from 0 to 31, value counts 0, 1 and 65535, four idling patterns");
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

>>> rice_block_decoder.f
+incdir+hdl
hdl/rbd_pkg.sv
hdl/rbd_ctrl.sv
hdl/rbd_datapath.sv
hdl/rice_block_decoder.sv
test/rice_block_decoder_tb.sv
